// ===== rtl/core/tlt_pkg.sv =====
package tlt_pkg;

  // field widths fixed by the interface
  localparam int COORD_W   = 32;
  localparam int FEED_W    = 32;
  localparam int OUT_ACC_W = 48;
  localparam int COUNT_W   = 32;

  // datapath widths of the distance and time engine
  localparam int DIFF_W     = COORD_W + 1;   // magnitude of a coordinate difference
  localparam int SQ_W       = 2 * DIFF_W;    // sum of three squares stays below 2^66
  localparam int ROOT_W     = DIFF_W;        // floor square root of the sum
  localparam int ROOT_STEPS = ROOT_W;        // one root bit per step
  localparam int SUB_W      = ROOT_W + 3;    // shared subtractor operand width
  localparam int PROD60_W   = ROOT_W + 6;    // distance times sixty
  localparam int SQ_LAST    = 3;             // last cycle of the square/accumulate phase

  typedef struct packed {
    logic                       first_point;
    logic signed [COORD_W-1:0]  x_pos;
    logic signed [COORD_W-1:0]  y_pos;
    logic signed [COORD_W-1:0]  z_pos;
    logic                       is_cutting;
    logic        [FEED_W-1:0]   feed_rate;
  } tlt_in_t;

  typedef struct packed {
    logic [OUT_ACC_W-1:0] total_length;
    logic [OUT_ACC_W-1:0] cutting_length;
    logic [OUT_ACC_W-1:0] elapsed_time;
    logic [COUNT_W-1:0]   point_total;
  } tlt_out_t;

  // engine status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

// ===== rtl/core/toolpath_length_time_accumulator.sv =====
// Toolpath length and time accumulator. Each input beat is one toolpath point; each
// point returns one result beat with the running path length, cutting length, elapsed
// time and point count, all saturating. A point with first_point set starts a new path
// and goes straight to the output state, as does the first point after reset. Any
// other point runs through an iterative engine built around one shared 36-bit
// subtractor: a squaring phase with one registered 33x33 multiplier,
// 33 square-root steps, a setup state and, when feed_rate is nonzero, 39 + FRAC_BITS
// restoring-divide steps. in_ready is high only while no point is in work; a finished
// result waits in the output register without holding off the next point, though
// that point's result cannot load until the held one is taken.
module toolpath_length_time_accumulator #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlt_pkg::tlt_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tlt_pkg::tlt_out_t  out_data
);
  import tlt_pkg::*;

  localparam int SUM_W = ACC_WIDTH + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_OUT  = 3'b100
  } top_state_t;

  top_state_t              state_r;
  logic [COORD_W-1:0]      prev_x_r, prev_y_r, prev_z_r;
  logic                    have_prev_r;
  logic                    cut_r;
  logic [ACC_WIDTH-1:0]    len_r, cut_len_r, time_r;
  logic [COUNT_W-1:0]      count_r;
  logic                    out_valid_r;
  tlt_out_t                out_data_r;

  logic                    in_acc;
  logic                    out_load;
  logic                    eng_start;
  logic [DIFF_W-1:0]       dx, dy, dz;
  eng_stat_t               eng_stat;
  logic [ROOT_W-1:0]       eng_dist;
  logic [ACC_WIDTH-1:0]    eng_tinc;
  logic [SUM_W-1:0]        len_sum, cut_sum, time_sum;
  logic [COUNT_W-1:0]      count_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign eng_start = in_acc && !in_data.first_point && have_prev_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // coordinate difference magnitudes
  function automatic logic [DIFF_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign dx = abs_diff(in_data.x_pos, prev_x_r);
  assign dy = abs_diff(in_data.y_pos, prev_y_r);
  assign dz = abs_diff(in_data.z_pos, prev_z_r);

  tlt_engine #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (eng_start),
    .dx      (dx),
    .dy      (dy),
    .dz      (dz),
    .feed    (in_data.feed_rate),
    .stat    (eng_stat),
    .seg_len (eng_dist),
    .tinc    (eng_tinc)
  );

  // saturating accumulate
  assign len_sum   = {1'b0, len_r} + SUM_W'(eng_dist);
  assign cut_sum   = {1'b0, cut_len_r} + SUM_W'(eng_dist);
  assign time_sum  = {1'b0, time_r} + SUM_W'(eng_tinc);
  assign count_inc = (count_r == '1) ? count_r : count_r + COUNT_W'(1);

  // control, accumulators and previous point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      len_r       <= '0;
      cut_len_r   <= '0;
      time_r      <= '0;
      count_r     <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_x_r    <= in_data.x_pos;
            prev_y_r    <= in_data.y_pos;
            prev_z_r    <= in_data.z_pos;
            have_prev_r <= 1'b1;
            if (in_data.first_point) begin
              len_r     <= '0;
              cut_len_r <= '0;
              time_r    <= '0;
              count_r   <= COUNT_W'(1);
              state_r   <= S_OUT;
            end else begin
              count_r <= count_inc;
              state_r <= have_prev_r ? S_CALC : S_OUT;
            end
          end
        end
        S_CALC: begin
          if (eng_stat.done) begin
            len_r  <= len_sum[ACC_WIDTH] ? '1 : len_sum[ACC_WIDTH-1:0];
            time_r <= time_sum[ACC_WIDTH] ? '1 : time_sum[ACC_WIDTH-1:0];
            if (cut_r) begin
              cut_len_r <= cut_sum[ACC_WIDTH] ? '1 : cut_sum[ACC_WIDTH-1:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // cutting flag of the point in work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cut_r <= in_data.is_cutting;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.total_length   <= OUT_ACC_W'(len_r);
      out_data_r.cutting_length <= OUT_ACC_W'(cut_len_r);
      out_data_r.elapsed_time   <= OUT_ACC_W'(time_r);
      out_data_r.point_total    <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // engine never runs while a new point can be taken
  a_ready_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !eng_stat.busy)
    else $error("input ready while engine busy");

  // engine finishes only while the top waits for it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.done |-> (state_r == S_CALC))
    else $error("engine done outside calc state");

  // cutting length never exceeds total length
  a_cut_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    cut_len_r <= len_r)
    else $error("cutting length above total length");

  // an accepted point leaves a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (count_r != '0))
    else $error("point count zero after accepted beat");

  // a result beat appears only out of the output state
  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside output state");

endmodule

// ===== rtl/core/tlt_engine.sv =====
module tlt_engine #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tlt_pkg::DIFF_W-1:0]    dx,
  input  logic [tlt_pkg::DIFF_W-1:0]    dy,
  input  logic [tlt_pkg::DIFF_W-1:0]    dz,
  input  logic [tlt_pkg::FEED_W-1:0]    feed,
  output tlt_pkg::eng_stat_t            stat,
  output logic [tlt_pkg::ROOT_W-1:0]    seg_len,
  output logic [ACC_WIDTH-1:0]          tinc
);
  import tlt_pkg::*;

  localparam int NUM_W = PROD60_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int QW    = (NUM_W > ACC_WIDTH) ? NUM_W : ACC_WIDTH;

  typedef enum logic [5:0] {
    E_IDLE = 6'b000001,
    E_SQ   = 6'b000010,
    E_ROOT = 6'b000100,
    E_LOAD = 6'b001000,
    E_DIV  = 6'b010000,
    E_FIN  = 6'b100000
  } eng_state_t;

  eng_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIFF_W-1:0]      dx_r, dy_r, dz_r;
  logic [FEED_W-1:0]      feed_r;
  logic [SQ_W-1:0]        prod_r;
  logic [SQ_W-1:0]        sum_r;
  logic [SUB_W-1:0]       rem_r;
  logic [ROOT_W-1:0]      root_r;
  logic [NUM_W-1:0]       num_r;

  logic [DIFF_W-1:0]      sq_op;
  logic [SQ_W-1:0]        sq_prod;
  logic [SUB_W-1:0]       root_rem_sh, root_trial, div_rem_sh;
  logic [SUB_W-1:0]       sub_a, sub_b;
  logic [SUB_W:0]         sub_diff;
  logic                   sub_ge;
  logic [PROD60_W-1:0]    dist60;
  logic [QW-1:0]          q_ext, max_ext;

  // square operand select and multiplier
  always_comb begin
    case (cnt_r)
      CNT_W'(0): sq_op = dx_r;
      CNT_W'(1): sq_op = dy_r;
      default:   sq_op = dz_r;
    endcase
  end
  assign sq_prod = sq_op * sq_op;

  // operands for the root and divide steps
  assign root_rem_sh = {rem_r[SUB_W-3:0], sum_r[SQ_W-1 -: 2]};
  assign root_trial  = SUB_W'({root_r, 2'b01});
  assign div_rem_sh  = SUB_W'({rem_r[FEED_W-1:0], num_r[NUM_W-1]});

  // shared subtract and compare unit
  always_comb begin
    if (state_r == E_DIV) begin
      sub_a = div_rem_sh;
      sub_b = SUB_W'(feed_r);
    end else begin
      sub_a = root_rem_sh;
      sub_b = root_trial;
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[SUB_W];

  // distance times sixty as 64*d - 4*d
  assign dist60 = (PROD60_W'(root_r) << 6) - (PROD60_W'(root_r) << 2);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          state_nxt = E_SQ;
          cnt_nxt   = '0;
        end
      end
      E_SQ: begin
        if (cnt_r == CNT_W'(SQ_LAST)) begin
          state_nxt = E_ROOT;
          cnt_nxt   = CNT_W'(ROOT_STEPS - 1);
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      E_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = E_LOAD;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      E_LOAD: begin
        if (feed_r == '0) begin
          state_nxt = E_FIN;
        end else begin
          state_nxt = E_DIV;
          cnt_nxt   = CNT_W'(NUM_W - 1);
        end
      end
      E_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = E_FIN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      E_FIN: begin
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      E_IDLE: begin
        if (start) begin
          dx_r   <= dx;
          dy_r   <= dy;
          dz_r   <= dz;
          feed_r <= feed;
          sum_r  <= '0;
        end
      end
      E_SQ: begin
        prod_r <= sq_prod;
        if (cnt_r != '0) begin
          sum_r <= sum_r + prod_r;
        end
        rem_r  <= '0;
        root_r <= '0;
      end
      E_ROOT: begin
        sum_r  <= sum_r << 2;
        rem_r  <= sub_ge ? sub_diff[SUB_W-1:0] : root_rem_sh;
        root_r <= {root_r[ROOT_W-2:0], sub_ge};
      end
      E_LOAD: begin
        num_r <= {dist60, {FRAC_BITS{1'b0}}};
        rem_r <= '0;
      end
      E_DIV: begin
        rem_r <= sub_ge ? sub_diff[SUB_W-1:0] : div_rem_sh;
        num_r <= {num_r[NUM_W-2:0], sub_ge};
      end
      default: begin
      end
    endcase
  end

  // quotient clamp and outputs
  assign q_ext   = QW'(num_r);
  assign max_ext = QW'({ACC_WIDTH{1'b1}});

  always_comb begin
    if (feed_r == '0) begin
      tinc = '0;
    end else if (q_ext > max_ext) begin
      tinc = '1;
    end else begin
      tinc = ACC_WIDTH'(num_r);
    end
  end

  assign seg_len   = root_r;
  assign stat.busy = (state_r != E_IDLE);
  assign stat.done = (state_r == E_FIN);

endmodule

// ===== tb/tb_toolpath_length_time_accumulator.sv =====
`timescale 1ns / 100ps

module tb_toolpath_length_time_accumulator;
  import tlt_pkg::*;

  localparam int          FRAC_BITS   = 16;
  localparam int          ACC_WIDTH   = 48;
  localparam logic [47:0] ACC_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam int          RAND_POINTS = 1850;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          MAX_REPORTS = 100;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tlt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tlt_out_t out_data;

  // points waiting to be sent, running totals waiting to come back
  tlt_in_t  pending_points[$];
  tlt_out_t expected_totals[$];

  // path state of the predictor
  logic [31:0] last_x, last_y, last_z;
  logic        have_last;
  logic [47:0] len_total, len_cut, secs_total;
  logic [31:0] pts_total;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int send_gap       = 0;
  int recv_stall     = 0;
  bit send_calm      = 1'b0;
  bit recv_calm      = 1'b0;

  toolpath_length_time_accumulator #(
    .FRAC_BITS(FRAC_BITS),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // magnitude of a coordinate difference
  function automatic logic [32:0] coord_gap(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  // floor square root, bit by bit from the top
  function automatic logic [35:0] floor_sqrt(input logic [71:0] n);
    logic [35:0] r;
    logic [71:0] tw;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      tw = {36'd0, r | (36'd1 << b)};
      if (tw * tw <= n) r = tw[35:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? ACC_MAX : s[47:0];
  endfunction

  // advance the path totals by one point
  task automatic predict_totals(input tlt_in_t pt, output tlt_out_t res);
    logic [32:0]  dx, dy, dz;
    logic [71:0]  sq_sum;
    logic [35:0]  seg_len;
    logic [127:0] scaled, quot;
    if (pt.first_point) begin
      len_total  = '0;
      len_cut    = '0;
      secs_total = '0;
      pts_total  = '0;
    end else if (have_last) begin
      dx = coord_gap(pt.x_pos, last_x);
      dy = coord_gap(pt.y_pos, last_y);
      dz = coord_gap(pt.z_pos, last_z);
      sq_sum = {39'd0, dx} * {39'd0, dx} + {39'd0, dy} * {39'd0, dy}
             + {39'd0, dz} * {39'd0, dz};
      seg_len = floor_sqrt(sq_sum);
      len_total = sat_add48(len_total, {12'd0, seg_len});
      if (pt.is_cutting) len_cut = sat_add48(len_cut, {12'd0, seg_len});
      // seconds = length * 60 / feed, kept in the same fixed-point format
      if (pt.feed_rate != '0) begin
        scaled = ({92'd0, seg_len} * 128'd60) << FRAC_BITS;
        quot   = scaled / {96'd0, pt.feed_rate};
        secs_total = sat_add48(secs_total,
                               (quot > {80'd0, ACC_MAX}) ? ACC_MAX : quot[47:0]);
      end
    end
    last_x    = pt.x_pos;
    last_y    = pt.y_pos;
    last_z    = pt.z_pos;
    have_last = 1'b1;
    if (pts_total != '1) pts_total++;
    res.total_length   = len_total;
    res.cutting_length = len_cut;
    res.elapsed_time   = secs_total;
    res.point_total    = pts_total;
  endtask

  task automatic push_point(input logic first, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic cut, input logic [31:0] feed);
    tlt_in_t pt;
    pt.first_point = first;
    pt.x_pos       = x;
    pt.y_pos       = y;
    pt.z_pos       = z;
    pt.is_cutting  = cut;
    pt.feed_rate   = feed;
    pending_points = {pending_points, pt};
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // input driver: one point per beat, random gap before each
  always @(posedge clk) begin
    tlt_out_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_totals(in_data, want);
        expected_totals = {expected_totals, want};
        pending_points.delete(0);
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 19);
      end
      if (in_valid && !in_ready) begin
        // hold the beat until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_points[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: compare each beat, then stall a random while on the next one
  always @(posedge clk) begin
    tlt_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_totals.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t unexpected beat expected none actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_totals.pop_front();
          check_field("total_length", want.total_length, out_data.total_length);
          check_field("cutting_length", want.cutting_length, out_data.cutting_length);
          check_field("elapsed_time", want.elapsed_time, out_data.elapsed_time);
          check_field("point_total", {16'd0, want.point_total},
                      {16'd0, out_data.point_total});
        end
        if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 19);
      end
      // stall counts only while a beat is waiting
      if (recv_stall > 0) begin
        out_ready <= 1'b0;
        if (out_valid && !out_ready) recv_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("toolpath_length_time_accumulator: mismatch");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] cx, cy, cz, delta, feed;
    logic        first, cut;
    int          sent, path_len, mode, shift;
    have_last  = 1'b0;
    len_total  = '0;
    len_cut    = '0;
    secs_total = '0;
    pts_total  = '0;
    last_x     = '0;
    last_y     = '0;
    last_z     = '0;

    // no previous point after reset, without the first flag
    push_point(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1, 32'h0064_0000);
    // 3-4-5 move at 600 mm/min, half a second
    push_point(1'b0, 32'h0004_0000, 32'h0006_0000, 32'h0003_0000, 1'b1, 32'h0258_0000);
    // rapid with zero feed
    push_point(1'b0, 32'hFFFF_0000, 32'h0006_0000, 32'h0000_8000, 1'b0, 32'h0000_0000);
    // zero-length move
    push_point(1'b0, 32'hFFFF_0000, 32'h0006_0000, 32'h0000_8000, 1'b1, 32'h0000_0001);
    // single lsb step, slowest feed
    push_point(1'b0, 32'hFFFF_0001, 32'h0006_0000, 32'h0000_8000, 1'b1, 32'h0000_0001);
    // new path at the most negative corner
    push_point(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
    // full diagonal to the most positive corner
    push_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // very slow feed saturates the elapsed time
    push_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0000_0001);
    push_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0002);
    push_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0001_0000);
    // new path clears the totals, cut flag and feed ignored
    push_point(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001);
    push_point(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000);
    // single axis moves
    push_point(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000);
    push_point(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000);
    push_point(1'b0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0000_00FF);
    push_point(1'b0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h4E20_0000);
    // lone first point followed by a first point again
    push_point(1'b1, 32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 1'b0, 32'h0000_0000);
    push_point(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hF0F0_F0F0, 1'b1, 32'hFFFF_FFFF);
    push_point(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 1'b1, 32'h0000_0003);

    // random paths: mostly local moves, some wild jumps, some broken starts
    cx = '0;
    cy = '0;
    cz = '0;
    sent = 0;
    while (sent < RAND_POINTS) begin
      path_len = $urandom_range(1, 40);
      for (int i = 0; i < path_len; i++) begin
        first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        mode = $urandom_range(0, 9);
        if (first || mode < 2) begin
          cx = $urandom;
          cy = $urandom;
          cz = $urandom;
        end else if (mode == 2) begin
          cx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          cy = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          cz = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else begin
          shift = $urandom_range(0, 24);
          delta = $urandom & ((32'd1 << shift) - 32'd1);
          cx = $urandom_range(0, 1) ? cx + delta : cx - delta;
          delta = $urandom & ((32'd1 << shift) - 32'd1);
          cy = $urandom_range(0, 1) ? cy + delta : cy - delta;
          delta = $urandom & ((32'd1 << $urandom_range(0, shift)) - 32'd1);
          cz = $urandom_range(0, 1) ? cz + delta : cz - delta;
        end
        mode = $urandom_range(0, 19);
        if (mode < 3)       feed = '0;
        else if (mode < 5)  feed = $urandom_range(1, 255);
        else if (mode < 7)  feed = $urandom;
        else                feed = $urandom_range(32'h0001_0000, 32'h4E20_0000);
        cut = $urandom_range(0, 1);
        push_point(first, cx, cy, cz, cut, feed);
        sent++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_points.size() > 0 || in_valid) @(posedge clk);
    while (expected_totals.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("toolpath_length_time_accumulator: match");
    else
      $display("toolpath_length_time_accumulator: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tlt_pkg.sv
rtl/core/tlt_engine.sv
rtl/core/toolpath_length_time_accumulator.sv
tb/tb_toolpath_length_time_accumulator.sv
